@@ rtl/fldc_pkg.sv @@
`default_nettype none

package fldc_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned UNIT_W  = 5;
    localparam int unsigned T12_W   = 15;

    localparam logic [UNIT_W-1:0] MAX_UNITS = 5'd16;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CFG_W-1:0] LOOP_DELAY_RST = 12'd116;
    localparam logic [CFG_W-1:0] FHM_DELAY_RST  = 12'd896;

    // floor(x/25) for x < 2**20 as (x * SCALE_RECIP) >> SCALE_SHIFT
    localparam int unsigned SCALE_SHIFT = 26;
    localparam logic [21:0] SCALE_RECIP =
        22'(((64'd1 << SCALE_SHIFT) + 64'd24) / 64'd25);

    typedef enum logic [1:0] {
        CFG_LOOP_DELAY = 2'd0,
        CFG_FHM_DL     = 2'd1,
        CFG_FHM_UL     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_UNIT   = 3'd0,
        KIND_DL_3G  = 3'd1,
        KIND_UL_3G  = 3'd2,
        KIND_DL_LTE = 3'd3,
        KIND_UL_LTE = 3'd4,
        KIND_FHM    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] loop_delay;
        logic [CFG_W-1:0] fhm_dl;
        logic [CFG_W-1:0] fhm_ul;
    } t_cfg;

    // equipment/delay order: 3G DL, 3G UL, LTE DL, LTE UL
    typedef struct packed {
        logic                    conn;
        logic                    last;
        logic [FIELD_W-1:0]      rt;
        logic [FIELD_W-1:0]      tof;
        logic [FIELD_W-1:0]      t12;
        logic [3:0][FIELD_W-1:0] equip;
        logic [3:0][FIELD_W-1:0] delay;
    } t_unit_item;

    typedef struct packed {
        t_kind              kind;
        logic [UNIT_W-1:0]  unit;
        logic               in_use;
        logic [T12_W-1:0]   t12;
        logic [FIELD_W-1:0] rt;
        logic [FIELD_W-1:0] tof;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] c;
        logic [FIELD_W-1:0] d;
        logic               last;
    } t_record;

endpackage

`default_nettype wire

@@ rtl/fldc_front.sv @@
`default_nettype none

module fldc_front
    import fldc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [CFG_W-1:0]    i_loop_delay,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_start_request,
    input  wire logic [1:0]          i_start_response,
    input  wire logic [FIELD_W-1:0]  i_round_trip_raw,
    input  wire logic                i_toffset_3g_ok,
    input  wire logic [FIELD_W-1:0]  i_toffset_3g,
    input  wire logic                i_toffset_lte_ok,
    input  wire logic [FIELD_W-1:0]  i_toffset_lte,
    input  wire logic [FIELD_W-1:0]  i_dl_equip_3g,
    input  wire logic [FIELD_W-1:0]  i_ul_equip_3g,
    input  wire logic [FIELD_W-1:0]  i_dl_equip_lte,
    input  wire logic [FIELD_W-1:0]  i_ul_equip_lte,
    input  wire logic                i_last_unit,
    output logic                     o_push_valid,
    input  wire logic                i_push_ready,
    output t_unit_item               o_push_item
);

    logic                    conn;
    logic [FIELD_W-1:0]      tof_sel;
    logic [FIELD_W:0]        t14_full;
    logic [FIELD_W-1:0]      t14;
    logic [19:0]             scale_num;
    logic [41:0]             scale_prod;
    logic [FIELD_W+1:0]      diff;
    logic [FIELD_W-1:0]      t12;

    logic                    r_s1_valid;
    logic                    r_conn;
    logic                    r_last;
    logic [FIELD_W-1:0]      r_rt;
    logic [FIELD_W-1:0]      r_tof;
    logic [FIELD_W-1:0]      r_t14;
    logic [FIELD_W-1:0]      r_scaled;
    logic [3:0][FIELD_W-1:0] r_equip;

    assign conn = (i_start_request != 2'b00) && (i_start_request == i_start_response);

    always_comb begin
        if (i_toffset_3g_ok) begin
            tof_sel = i_toffset_3g;
        end else if (i_toffset_lte_ok) begin
            tof_sel = i_toffset_lte;
        end else begin
            tof_sel = '0;
        end
    end

    assign t14_full   = {1'b0, i_round_trip_raw} - {4'b0000, i_loop_delay, 1'b0};
    assign t14        = t14_full[FIELD_W] ? '0 : t14_full[FIELD_W-1:0];
    // (32*tof + 25) / 50 == (16*tof + 12) / 25
    assign scale_num  = {tof_sel, 4'b1100};
    assign scale_prod = 42'(scale_num) * 42'(SCALE_RECIP);

    assign o_in_ready = !r_s1_valid || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_conn     <= conn;
            r_last     <= i_last_unit;
            r_rt       <= conn ? i_round_trip_raw : '0;
            r_tof      <= conn ? tof_sel : '0;
            r_t14      <= t14;
            r_scaled   <= scale_prod[SCALE_SHIFT+FIELD_W-1:SCALE_SHIFT];
            r_equip[0] <= i_dl_equip_3g;
            r_equip[1] <= i_ul_equip_3g;
            r_equip[2] <= i_dl_equip_lte;
            r_equip[3] <= i_ul_equip_lte;
        end
    end

    assign diff = {2'b00, r_t14} - {2'b00, r_scaled} + 18'd1;
    assign t12  = (r_conn && !diff[FIELD_W+1] && (diff != '0)) ? diff[FIELD_W:1] : '0;

    always_comb begin
        o_push_item.conn  = r_conn;
        o_push_item.last  = r_last;
        o_push_item.rt    = r_rt;
        o_push_item.tof   = r_tof;
        o_push_item.t12   = t12;
        o_push_item.equip = r_equip;
        for (int k = 0; k < 4; k++) begin
            o_push_item.delay[k] = r_conn ? (t12 + r_equip[k]) : '0;
        end
    end

    assign o_push_valid = r_s1_valid;

endmodule

`default_nettype wire

@@ rtl/fldc_queue.sv @@
`default_nettype none

module fldc_queue
    import fldc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push_valid,
    output logic             o_push_ready,
    input  wire t_unit_item  i_push_item,
    output logic             o_pop_valid,
    input  wire logic        i_pop_ready,
    output t_unit_item       o_pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_unit_item         r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fldc_back.sv @@
`default_nettype none

module fldc_back
    import fldc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W-1:0]   i_fhm_dl,
    input  wire logic [CFG_W-1:0]   i_fhm_ul,
    input  wire logic               i_q_valid,
    output logic                    o_q_ready,
    input  wire t_unit_item         i_q_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_record                 o_record
);

    typedef enum logic [2:0] {
        ST_UNIT = 3'b001,
        ST_BASE = 3'b010,
        ST_FHM  = 3'b100
    } t_state;

    t_state                  r_state,     n_state;
    logic [1:0]              r_idx,       n_idx;
    logic [UNIT_W-1:0]       r_unit_cnt,  n_unit_cnt;
    logic [FIELD_W-1:0]      r_t12_max,   n_t12_max;
    logic [UNIT_W-1:0]       r_t12_unit,  n_t12_unit;
    logic [FIELD_W-1:0]      r_first_t12, n_first_t12;
    logic [3:0][FIELD_W-1:0] r_eq_max,    n_eq_max;
    logic [3:0][UNIT_W-1:0]  r_eq_unit,   n_eq_unit;
    logic [3:0][FIELD_W-1:0] r_dly_max,   n_dly_max;
    logic [3:0][UNIT_W-1:0]  r_dly_unit,  n_dly_unit;
    logic                    r_out_valid, n_out_valid;
    t_record                 r_record;

    logic                    out_free;
    logic                    load;
    t_record                 rec_d;
    t_record                 unit_rec;
    t_record                 base_rec;
    t_record                 fhm_rec;
    logic [FIELD_W-1:0]      base;
    t_kind                   base_kind;
    logic [FIELD_W-1:0]      fhm;
    logic [FIELD_W+1:0]      rep_full;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unit_rec        = '0;
        unit_rec.kind   = KIND_UNIT;
        unit_rec.unit   = r_unit_cnt;
        unit_rec.in_use = i_q_item.conn;
        unit_rec.t12    = i_q_item.t12[T12_W-1:0];
        unit_rec.rt     = i_q_item.rt;
        unit_rec.tof    = i_q_item.tof;
        unit_rec.a      = i_q_item.delay[0];
        unit_rec.b      = i_q_item.delay[2];
        unit_rec.c      = i_q_item.delay[1];
        unit_rec.d      = i_q_item.delay[3];
        unit_rec.last   = !i_q_item.last;
    end

    always_comb begin
        unique case (r_idx)
            2'd0:    base_kind = KIND_DL_3G;
            2'd1:    base_kind = KIND_UL_3G;
            2'd2:    base_kind = KIND_DL_LTE;
            2'd3:    base_kind = KIND_UL_LTE;
            default: base_kind = KIND_DL_3G;
        endcase
        if (r_dly_unit[r_idx] == r_t12_unit) begin
            base = r_dly_max[r_idx];
        end else begin
            base = r_t12_max + r_eq_max[r_idx];
        end
        base_rec      = '0;
        base_rec.kind = base_kind;
        base_rec.unit = r_dly_unit[r_idx];
        base_rec.a    = base;
        base_rec.b    = {base[FIELD_W-1:6] + 10'd1, 6'd0};
        base_rec.c    = FIELD_W'(r_eq_unit[r_idx]);
    end

    assign fhm      = {r_t12_max[FIELD_W-2:0], 1'b0} + FIELD_W'(i_fhm_dl)
                    + FIELD_W'(i_fhm_ul);
    assign rep_full = {2'b00, fhm}
                    - {({1'b0, r_first_t12} + (FIELD_W+1)'(i_fhm_dl)), 1'b0};

    always_comb begin
        fhm_rec      = '0;
        fhm_rec.kind = KIND_FHM;
        fhm_rec.unit = r_t12_unit;
        fhm_rec.t12  = r_t12_max[T12_W-1:0];
        fhm_rec.a    = fhm;
        fhm_rec.b    = rep_full[FIELD_W+1] ? '0 : rep_full[FIELD_W-1:0];
        fhm_rec.last = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_unit_cnt  = r_unit_cnt;
        n_t12_max   = r_t12_max;
        n_t12_unit  = r_t12_unit;
        n_first_t12 = r_first_t12;
        n_eq_max    = r_eq_max;
        n_eq_unit   = r_eq_unit;
        n_dly_max   = r_dly_max;
        n_dly_unit  = r_dly_unit;
        o_q_ready   = 1'b0;
        load        = 1'b0;
        rec_d       = unit_rec;

        unique case (r_state)
            ST_UNIT: begin
                o_q_ready = out_free;
                if (i_q_valid && out_free) begin
                    load = 1'b1;
                    if (i_q_item.conn) begin
                        if (r_t12_max < i_q_item.t12) begin
                            n_t12_max  = i_q_item.t12;
                            n_t12_unit = r_unit_cnt;
                        end
                        for (int k = 0; k < 4; k++) begin
                            if (r_eq_max[k] < i_q_item.equip[k]) begin
                                n_eq_max[k]  = i_q_item.equip[k];
                                n_eq_unit[k] = r_unit_cnt;
                            end
                            if (r_dly_max[k] < i_q_item.delay[k]) begin
                                n_dly_max[k]  = i_q_item.delay[k];
                                n_dly_unit[k] = r_unit_cnt;
                            end
                        end
                    end
                    if (r_unit_cnt == UNIT_W'(1)) begin
                        n_first_t12 = i_q_item.t12;
                    end
                    if (i_q_item.last) begin
                        n_state = ST_BASE;
                        n_idx   = '0;
                    end else if (r_unit_cnt < MAX_UNITS) begin
                        n_unit_cnt = r_unit_cnt + 1'b1;
                    end
                end
            end
            ST_BASE: begin
                rec_d = base_rec;
                if (out_free) begin
                    load  = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        n_state = ST_FHM;
                    end
                end
            end
            ST_FHM: begin
                rec_d = fhm_rec;
                if (out_free) begin
                    load        = 1'b1;
                    n_state     = ST_UNIT;
                    n_unit_cnt  = UNIT_W'(1);
                    n_t12_max   = '0;
                    n_t12_unit  = UNIT_W'(1);
                    n_first_t12 = '0;
                    for (int k = 0; k < 4; k++) begin
                        n_eq_max[k]   = '0;
                        n_eq_unit[k]  = UNIT_W'(1);
                        n_dly_max[k]  = '0;
                        n_dly_unit[k] = UNIT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_UNIT;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_UNIT;
            r_idx       <= '0;
            r_unit_cnt  <= UNIT_W'(1);
            r_t12_max   <= '0;
            r_t12_unit  <= UNIT_W'(1);
            r_first_t12 <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_eq_max[k]   <= '0;
                r_eq_unit[k]  <= UNIT_W'(1);
                r_dly_max[k]  <= '0;
                r_dly_unit[k] <= UNIT_W'(1);
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_unit_cnt  <= n_unit_cnt;
            r_t12_max   <= n_t12_max;
            r_t12_unit  <= n_t12_unit;
            r_first_t12 <= n_first_t12;
            r_out_valid <= n_out_valid;
            r_eq_max    <= n_eq_max;
            r_eq_unit   <= n_eq_unit;
            r_dly_max   <= n_dly_max;
            r_dly_unit  <= n_dly_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_record <= rec_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_record    = r_record;

endmodule

`default_nettype wire

@@ rtl/fronthaul_link_delay_calibrator_unit.sv @@
// Fronthaul link delay calibrator.
// Input channel (i_in_valid/o_in_ready): one beat per radio unit, units are
// numbered from 1 in arrival order; i_last_unit closes the batch.
// Output channel (o_out_valid/i_out_ready): one per-unit record per beat; the
// last unit of a batch is followed by four base-delay records and one FHM
// toffset record, o_last_result marking the final record of that unit.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (loop delay,
// FHM DL delay, FHM UL delay) in the same cycle; write only while idle.
// A unit record passes the front register, the queue and the output register.
// Throughput: 1 unit per cycle unless the output stalls or the back-end
// sequencer is emitting a batch's base-delay and FHM records, which it does
// at one record per cycle while the output is not stalled.
// The front stage and a QUEUE_DEPTH-entry queue keep accepting while the
// output is stalled; once they fill, o_in_ready drops until records drain.
// Reset: configuration returns to 116/896/896, all maxima clear, the unit
// counter returns to 1, no records pending. The batch state also clears
// after the FHM toffset record.
`default_nettype none

module fronthaul_link_delay_calibrator_unit
    import fldc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_start_request,
    input  wire logic [1:0]          i_start_response,
    input  wire logic [FIELD_W-1:0]  i_round_trip_raw,
    input  wire logic                i_toffset_3g_ok,
    input  wire logic [FIELD_W-1:0]  i_toffset_3g,
    input  wire logic                i_toffset_lte_ok,
    input  wire logic [FIELD_W-1:0]  i_toffset_lte,
    input  wire logic [FIELD_W-1:0]  i_dl_equip_3g,
    input  wire logic [FIELD_W-1:0]  i_ul_equip_3g,
    input  wire logic [FIELD_W-1:0]  i_dl_equip_lte,
    input  wire logic [FIELD_W-1:0]  i_ul_equip_lte,
    input  wire logic                i_last_unit,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [2:0]               o_record_kind,
    output logic [UNIT_W-1:0]        o_unit_number,
    output logic                     o_in_use,
    output logic [T12_W-1:0]         o_t12_value,
    output logic [FIELD_W-1:0]       o_round_trip_out,
    output logic [FIELD_W-1:0]       o_toffset_out,
    output logic [FIELD_W-1:0]       o_value_a,
    output logic [FIELD_W-1:0]       o_value_b,
    output logic [FIELD_W-1:0]       o_value_c,
    output logic [FIELD_W-1:0]       o_value_d,
    output logic                     o_last_result
);

    t_cfg        r_cfg;
    logic        push_valid;
    logic        push_ready;
    t_unit_item  push_item;
    logic        q_valid;
    logic        q_ready;
    t_unit_item  q_item;
    t_record     record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_delay <= LOOP_DELAY_RST;
            r_cfg.fhm_dl     <= FHM_DELAY_RST;
            r_cfg.fhm_ul     <= FHM_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOOP_DELAY: r_cfg.loop_delay <= i_cfg_data;
                CFG_FHM_DL:     r_cfg.fhm_dl     <= i_cfg_data;
                CFG_FHM_UL:     r_cfg.fhm_ul     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fldc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_loop_delay     (r_cfg.loop_delay),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_request  (i_start_request),
        .i_start_response (i_start_response),
        .i_round_trip_raw (i_round_trip_raw),
        .i_toffset_3g_ok  (i_toffset_3g_ok),
        .i_toffset_3g     (i_toffset_3g),
        .i_toffset_lte_ok (i_toffset_lte_ok),
        .i_toffset_lte    (i_toffset_lte),
        .i_dl_equip_3g    (i_dl_equip_3g),
        .i_ul_equip_3g    (i_ul_equip_3g),
        .i_dl_equip_lte   (i_dl_equip_lte),
        .i_ul_equip_lte   (i_ul_equip_lte),
        .i_last_unit      (i_last_unit),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_item      (push_item)
    );

    fldc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    fldc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fhm_dl    (r_cfg.fhm_dl),
        .i_fhm_ul    (r_cfg.fhm_ul),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_record    (record)
    );

    assign o_record_kind    = record.kind;
    assign o_unit_number    = record.unit;
    assign o_in_use         = record.in_use;
    assign o_t12_value      = record.t12;
    assign o_round_trip_out = record.rt;
    assign o_toffset_out    = record.tof;
    assign o_value_a        = record.a;
    assign o_value_b        = record.b;
    assign o_value_c        = record.c;
    assign o_value_d        = record.d;
    assign o_last_result    = record.last;

endmodule

`default_nettype wire

@@ tb/sv/fronthaul_link_delay_calibrator_unit_tb.sv @@
`timescale 1ns / 100ps

module fronthaul_link_delay_calibrator_unit_tb;
    import fldc_pkg::*;

    localparam int DRAIN_LIMIT    = 20000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PRINT_CAP      = 200;

    typedef struct {
        logic [1:0]              req;
        logic [1:0]              rsp;
        logic [FIELD_W-1:0]      rt;
        logic                    ok3;
        logic [FIELD_W-1:0]      tof3;
        logic                    okl;
        logic [FIELD_W-1:0]      tofl;
        logic [3:0][FIELD_W-1:0] equip;  // 3G DL, 3G UL, LTE DL, LTE UL
        logic                    last;
    } t_unit_beat;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_start_request;
    logic [1:0]          i_start_response;
    logic [FIELD_W-1:0]  i_round_trip_raw;
    logic                i_toffset_3g_ok;
    logic [FIELD_W-1:0]  i_toffset_3g;
    logic                i_toffset_lte_ok;
    logic [FIELD_W-1:0]  i_toffset_lte;
    logic [FIELD_W-1:0]  i_dl_equip_3g;
    logic [FIELD_W-1:0]  i_ul_equip_3g;
    logic [FIELD_W-1:0]  i_dl_equip_lte;
    logic [FIELD_W-1:0]  i_ul_equip_lte;
    logic                i_last_unit;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [2:0]          o_record_kind;
    logic [UNIT_W-1:0]   o_unit_number;
    logic                o_in_use;
    logic [T12_W-1:0]    o_t12_value;
    logic [FIELD_W-1:0]  o_round_trip_out;
    logic [FIELD_W-1:0]  o_toffset_out;
    logic [FIELD_W-1:0]  o_value_a;
    logic [FIELD_W-1:0]  o_value_b;
    logic [FIELD_W-1:0]  o_value_c;
    logic [FIELD_W-1:0]  o_value_d;
    logic                o_last_result;

    fronthaul_link_delay_calibrator_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_request  (i_start_request),
        .i_start_response (i_start_response),
        .i_round_trip_raw (i_round_trip_raw),
        .i_toffset_3g_ok  (i_toffset_3g_ok),
        .i_toffset_3g     (i_toffset_3g),
        .i_toffset_lte_ok (i_toffset_lte_ok),
        .i_toffset_lte    (i_toffset_lte),
        .i_dl_equip_3g    (i_dl_equip_3g),
        .i_ul_equip_3g    (i_ul_equip_3g),
        .i_dl_equip_lte   (i_dl_equip_lte),
        .i_ul_equip_lte   (i_ul_equip_lte),
        .i_last_unit      (i_last_unit),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_kind    (o_record_kind),
        .o_unit_number    (o_unit_number),
        .o_in_use         (o_in_use),
        .o_t12_value      (o_t12_value),
        .o_round_trip_out (o_round_trip_out),
        .o_toffset_out    (o_toffset_out),
        .o_value_a        (o_value_a),
        .o_value_b        (o_value_b),
        .o_value_c        (o_value_c),
        .o_value_d        (o_value_d),
        .o_last_result    (o_last_result)
    );

    // calibration model state
    logic [CFG_W-1:0]   cfg_loop   = LOOP_DELAY_RST;
    logic [CFG_W-1:0]   cfg_fhm_dl = FHM_DELAY_RST;
    logic [CFG_W-1:0]   cfg_fhm_ul = FHM_DELAY_RST;
    logic [UNIT_W-1:0]  unit_cnt;
    logic [FIELD_W-1:0] t12_max;
    logic [UNIT_W-1:0]  t12_max_unit;
    logic [FIELD_W-1:0] unit1_t12;
    logic [FIELD_W-1:0] eq_max [4];
    logic [UNIT_W-1:0]  eq_max_unit [4];
    logic [FIELD_W-1:0] dly_max [4];
    logic [UNIT_W-1:0]  dly_max_unit [4];

    t_record pending_records [$];

    int  mismatch_count  = 0;
    int  records_seen    = 0;
    int  units_sent      = 0;
    int  batches_sent    = 0;
    int  settings_loaded = 0;
    bit  tx_idle_en      = 1'b1;
    bit  rx_idle_en      = 1'b1;
    int  rx_stall_left   = 0;
    logic rx_hold        = 1'b0;
    event rx_hold_go;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(rx_hold_go);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            i_out_ready   <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            i_out_ready   <= 1'b0;
            rx_stall_left <= $urandom_range(0, 13);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic clear_batch_state();
        unit_cnt     = 5'd1;
        t12_max      = '0;
        t12_max_unit = 5'd1;
        unit1_t12    = '0;
        for (int i = 0; i < 4; i++) begin
            eq_max[i]       = '0;
            eq_max_unit[i]  = 5'd1;
            dly_max[i]      = '0;
            dly_max_unit[i] = 5'd1;
        end
    endtask

    task automatic predict_records(input t_unit_beat u);
        t_record            rec;
        logic               conn;
        int                 t14;
        int                 scaled;
        int                 diff;
        int                 rep;
        logic [FIELD_W-1:0] t12;
        logic [FIELD_W-1:0] rt_used;
        logic [FIELD_W-1:0] tof_sel;
        logic [FIELD_W-1:0] dly [4];
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] fhm;
        logic [UNIT_W-1:0]  unit;
        unit    = unit_cnt;
        conn    = (u.req != 2'd0) && (u.req == u.rsp);
        t12     = '0;
        rt_used = '0;
        tof_sel = '0;
        for (int i = 0; i < 4; i++) dly[i] = '0;
        if (conn) begin
            tof_sel = u.ok3 ? u.tof3 : (u.okl ? u.tofl : 16'd0);
            rt_used = u.rt;
            t14 = int'(u.rt) - 2 * int'(cfg_loop);
            if (t14 < 0) t14 = 0;
            scaled = (32 * int'(tof_sel) + 25) / 50;
            diff   = t14 - scaled + 1;
            t12    = (diff > 0) ? 16'(diff / 2) : 16'd0;
            for (int i = 0; i < 4; i++) dly[i] = t12 + u.equip[i];
            if (t12_max < t12) begin
                t12_max      = t12;
                t12_max_unit = unit;
            end
            for (int i = 0; i < 4; i++) begin
                if (eq_max[i] < u.equip[i]) begin
                    eq_max[i]      = u.equip[i];
                    eq_max_unit[i] = unit;
                end
                if (dly_max[i] < dly[i]) begin
                    dly_max[i]      = dly[i];
                    dly_max_unit[i] = unit;
                end
            end
        end
        if (unit == 5'd1) unit1_t12 = t12;

        rec        = '0;
        rec.kind   = KIND_UNIT;
        rec.unit   = unit;
        rec.in_use = conn;
        rec.t12    = t12[T12_W-1:0];
        rec.rt     = rt_used;
        rec.tof    = tof_sel;
        rec.a      = dly[0];
        rec.b      = dly[2];
        rec.c      = dly[1];
        rec.d      = dly[3];
        rec.last   = !u.last;
        pending_records.push_back(rec);

        if (u.last) begin
            for (int i = 0; i < 4; i++) begin
                base = (dly_max_unit[i] == t12_max_unit) ? dly_max[i] : t12_max + eq_max[i];
                rec  = '0;
                case (i)
                    0: rec.kind = KIND_DL_3G;
                    1: rec.kind = KIND_UL_3G;
                    2: rec.kind = KIND_DL_LTE;
                    default: rec.kind = KIND_UL_LTE;
                endcase
                rec.unit = dly_max_unit[i];
                rec.a    = base;
                rec.b    = base + (16'd64 - {10'd0, base[5:0]});
                rec.c    = 16'(eq_max_unit[i]);
                pending_records.push_back(rec);
            end
            fhm = 16'(2 * int'(t12_max) + int'(cfg_fhm_dl) + int'(cfg_fhm_ul));
            rep = int'(fhm) - 2 * (int'(unit1_t12) + int'(cfg_fhm_dl));
            if (rep < 0) rep = 0;
            rec      = '0;
            rec.kind = KIND_FHM;
            rec.unit = t12_max_unit;
            rec.t12  = t12_max[T12_W-1:0];
            rec.a    = fhm;
            rec.b    = 16'(rep);
            rec.last = 1'b1;
            pending_records.push_back(rec);
            clear_batch_state();
        end else if (unit_cnt < MAX_UNITS) begin
            unit_cnt = unit_cnt + 5'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            if (mismatch_count < PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_record want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                if (mismatch_count < PRINT_CAP)
                    $display("%0t: unexpected record, expected none, got kind %0d unit %0d",
                             $time, o_record_kind, o_unit_number);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", 16'(want.kind), 16'(o_record_kind));
                check_field("unit_number", 16'(want.unit), 16'(o_unit_number));
                check_field("in_use", 16'(want.in_use), 16'(o_in_use));
                check_field("t12_value", 16'(want.t12), 16'(o_t12_value));
                check_field("round_trip_out", want.rt, o_round_trip_out);
                check_field("toffset_out", want.tof, o_toffset_out);
                check_field("value_a", want.a, o_value_a);
                check_field("value_b", want.b, o_value_b);
                check_field("value_c", want.c, o_value_c);
                check_field("value_d", want.d, o_value_d);
                check_field("last_result", 16'(want.last), 16'(o_last_result));
                records_seen++;
            end
        end
    end

    function automatic t_unit_beat make_unit(
        input logic [1:0] req, input logic [1:0] rsp, input logic [15:0] rt,
        input logic ok3, input logic [15:0] tof3, input logic okl, input logic [15:0] tofl,
        input logic [15:0] e0, input logic [15:0] e1, input logic [15:0] e2,
        input logic [15:0] e3, input logic last);
        t_unit_beat u;
        u.req      = req;
        u.rsp      = rsp;
        u.rt       = rt;
        u.ok3      = ok3;
        u.tof3     = tof3;
        u.okl      = okl;
        u.tofl     = tofl;
        u.equip[0] = e0;
        u.equip[1] = e1;
        u.equip[2] = e2;
        u.equip[3] = e3;
        u.last     = last;
        return u;
    endfunction

    function automatic t_unit_beat random_unit(input bit last_flag);
        t_unit_beat u;
        if ($urandom_range(0, 99) < 75) begin
            u.req = 2'($urandom_range(1, 3));
            u.rsp = u.req;
        end else begin
            u.req = 2'($urandom);
            u.rsp = 2'($urandom);
        end
        u.rt   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8000)) : 16'($urandom);
        u.ok3  = 1'($urandom);
        u.okl  = 1'($urandom);
        u.tof3 = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
        u.tofl = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
        for (int i = 0; i < 4; i++)
            u.equip[i] = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3000))
                                                    : 16'($urandom);
        u.last = last_flag;
        return u;
    endfunction

    task automatic send_unit(input t_unit_beat u);
        int gap;
        i_in_valid       <= 1'b1;
        i_start_request  <= u.req;
        i_start_response <= u.rsp;
        i_round_trip_raw <= u.rt;
        i_toffset_3g_ok  <= u.ok3;
        i_toffset_3g     <= u.tof3;
        i_toffset_lte_ok <= u.okl;
        i_toffset_lte    <= u.tofl;
        i_dl_equip_3g    <= u.equip[0];
        i_ul_equip_3g    <= u.equip[1];
        i_dl_equip_lte   <= u.equip[2];
        i_ul_equip_lte   <= u.equip[3];
        i_last_unit      <= u.last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_records(u);
        units_sent++;
        if (u.last) batches_sent++;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_batch(input int len);
        for (int k = 0; k < len; k++) send_unit(random_unit(k == len - 1));
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_records.size() != 0) begin
            $display("%0t: records missing, expected %0d more, got 0",
                     $time, pending_records.size());
            mismatch_count++;
            pending_records.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] x,
                               input logic [CFG_W-1:0] y);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOOP_DELAY;
        i_cfg_data  <= lp;
        @(posedge i_clk);
        i_cfg_index <= CFG_FHM_DL;
        i_cfg_data  <= x;
        @(posedge i_clk);
        i_cfg_index <= CFG_FHM_UL;
        i_cfg_data  <= y;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_loop   = lp;
        cfg_fhm_dl = x;
        cfg_fhm_ul = y;
        settings_loaded++;
    endtask

    task automatic load_random_config();
        logic [CFG_W-1:0] lp;
        lp = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
        load_config(lp, 12'($urandom), 12'($urandom));
    endtask

    // reset settings: connection rules, toffset selection, clamps, strict maxima
    task automatic test_default_config();
        send_unit(make_unit(2'd3, 2'd3, 16'd1000, 1'b1, 16'd500, 1'b1, 16'd9999,
                            16'd100, 16'd200, 16'd300, 16'd400, 1'b0));
        send_unit(make_unit(2'd1, 2'd1, 16'd3000, 1'b0, 16'd7, 1'b1, 16'd100,
                            16'd10, 16'd20, 16'd30, 16'd40, 1'b0));
        send_unit(make_unit(2'd2, 2'd2, 16'd500, 1'b0, 16'd900, 1'b0, 16'd900,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_unit(make_unit(2'd0, 2'd0, 16'd5000, 1'b1, 16'd1, 1'b1, 16'd1,
                            16'hF000, 16'hF000, 16'hF000, 16'hF000, 1'b0));
        send_unit(make_unit(2'd3, 2'd1, 16'd5000, 1'b0, 16'd0, 1'b0, 16'd0,
                            16'hF000, 16'hF000, 16'hF000, 16'hF000, 1'b0));
        send_unit(make_unit(2'd1, 2'd1, 16'd100, 1'b1, 16'd0, 1'b0, 16'd0,
                            16'd5, 16'd5, 16'd5, 16'd5, 1'b0));
        send_unit(make_unit(2'd3, 2'd3, 16'd2000, 1'b1, 16'hFFFF, 1'b0, 16'd0,
                            16'd1, 16'd2, 16'd3, 16'd4, 1'b0));
        send_unit(make_unit(2'd1, 2'd1, 16'd3000, 1'b0, 16'd7, 1'b1, 16'd100,
                            16'd10, 16'd20, 16'd30, 16'd40, 1'b1));
        // batch without any connected unit
        send_unit(make_unit(2'd2, 2'd1, 16'd4000, 1'b1, 16'd10, 1'b1, 16'd10,
                            16'd50, 16'd50, 16'd50, 16'd50, 1'b1));
        // base already on a 64 boundary
        send_unit(make_unit(2'd3, 2'd3, 16'd360, 1'b0, 16'd0, 1'b0, 16'd0,
                            16'd64, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        load_config(12'd0, 12'hFFF, 12'hFFF);
        send_unit(make_unit(2'd1, 2'd2, 16'd100, 1'b0, 16'd0, 1'b0, 16'd0,
                            16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_unit(make_unit(2'd3, 2'd3, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF,
                            16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 1'b1));
        wait_idle();
        load_config(12'hFFF, 12'd0, 12'd0);
        send_unit(make_unit(2'd3, 2'd3, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'd0,
                            16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0));
        send_unit(make_unit(2'd2, 2'd2, 16'd0, 1'b0, 16'd0, 1'b1, 16'hFFFF,
                            16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_idle();
        // unit 1 holds the maximum, negative toffset report clamps
        load_config(12'd116, 12'hFFF, 12'd0);
        send_unit(make_unit(2'd3, 2'd3, 16'd3000, 1'b0, 16'd0, 1'b0, 16'd0,
                            16'd1, 16'd1, 16'd1, 16'd1, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_batches();
        int  phase_units;
        int  len;
        bit  first_batch;
        first_batch = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            load_random_config();
            phase_units = 0;
            while (phase_units < 40) begin
                if (first_batch)
                    len = 18;  // counter saturation
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(17, 20);
                else
                    len = $urandom_range(1, 8);
                first_batch = 1'b0;
                send_random_batch(len);
                phase_units += len;
            end
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        -> rx_hold_go;
        send_random_batch(12);
        send_random_batch(15);
        send_random_batch(13);
        tx_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_streaming_no_idle();
        int sent;
        sent = 0;
        load_random_config();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (sent < 70) begin
            send_random_batch(8);
            sent += 8;
        end
    endtask

    initial begin
        clear_batch_state();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_LOOP_DELAY;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_start_request  <= '0;
        i_start_response <= '0;
        i_round_trip_raw <= '0;
        i_toffset_3g_ok  <= 1'b0;
        i_toffset_3g     <= '0;
        i_toffset_lte_ok <= 1'b0;
        i_toffset_lte    <= '0;
        i_dl_equip_3g    <= '0;
        i_ul_equip_3g    <= '0;
        i_dl_equip_lte   <= '0;
        i_ul_equip_lte   <= '0;
        i_last_unit      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_register_extremes();
        test_random_batches();
        test_output_backpressure();
        test_streaming_no_idle();
        wait_idle();

        $display("Sent %0d radio units in %0d batches under %0d register settings,",
                 units_sent, batches_sent, settings_loaded);
        $display("checked %0d records with random stalls and a long output hold-off",
                 records_seen);
        if (mismatch_count == 0 && pending_records.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
